FILE: hw/rtl/http_request_line_validator_unit_macros.svh
// ----------------------------------------------------------------------------
// HTTP request line validator: assertion macros
// Shared clocked concurrent property helpers for the validator modules.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_VALIDATOR_UNIT_MACROS_SVH
`define HTTP_REQUEST_LINE_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define HRLV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define HRLV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/hrlv_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request line validator: shared package
// Byte classes, parser state, status codes and constants.
// ----------------------------------------------------------------------------
package hrlv_pkg;

   // Header lines counted before saturation
   localparam logic [3:0] HEADER_LIMIT = 4'd10;

   // Queue between classifier and parser
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Character constants
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   // Header line position codes
   localparam logic [1:0] LP_START = 2'd0;
   localparam logic [1:0] LP_CR    = 2'd1;
   localparam logic [1:0] LP_TEXT  = 2'd2;

   // Verb candidate bits
   localparam logic [1:0] VC_GET  = 2'b01;
   localparam logic [1:0] VC_POST = 2'b10;
   localparam logic [1:0] VC_BOTH = 2'b11;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_IO          = 3'd1,
      ST_BAD_VERB    = 3'd2,
      ST_BAD_PATH    = 3'd3,
      ST_BAD_VERSION = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      PH_SKIP    = 4'd0,
      PH_VERB    = 4'd1,
      PH_GAP     = 4'd2,
      PH_PATH    = 4'd3,
      PH_VERS    = 4'd4,
      PH_BADVERB = 4'd5,
      PH_BADPATH = 4'd6,
      PH_BADVERS = 4'd7,
      PH_HEAD    = 4'd8,
      PH_TAIL    = 4'd9,
      PH_DONE    = 4'd10
   } phase_type;

   // Classified request byte
   typedef struct packed {
      logic end_marker;
      logic is_sp;
      logic is_cr;
      logic is_lf;
      logic is_slash;
      logic path_ok;
      logic vers_ok;
      logic is_g;
      logic is_e;
      logic is_t;
      logic is_p;
      logic is_o;
      logic is_s;
   } token_type;

   localparam token_type CR_TOKEN = '{is_cr: 1'b1, default: 1'b0};

   // Parser state
   typedef struct packed {
      phase_type   phase;
      logic [2:0]  vpos;
      logic [1:0]  vcand;
      logic [15:0] path_cnt;
      logic [15:0] vers_cnt;
      logic [3:0]  hdr_cnt;
      logic [1:0]  line_pos;
      logic        bare;
      logic        pend_cr;
   } back_state_type;

   localparam back_state_type BACK_RESET = '{
      phase:    PH_SKIP,
      vpos:     3'd0,
      vcand:    VC_BOTH,
      path_cnt: 16'd0,
      vers_cnt: 16'd0,
      hdr_cnt:  4'd0,
      line_pos: LP_START,
      bare:     1'b0,
      pend_cr:  1'b0
   };

   // Queue handshake between the front and back ends
   typedef struct packed {
      logic      valid;
      token_type tok;
   } queue_out_type;

endpackage

FILE: hw/rtl/hrlv_front.sv
// ----------------------------------------------------------------------------
// HTTP request line validator: front end
// Accepts request bytes and reduces each to a set of character class flags.
// ----------------------------------------------------------------------------
module hrlv_front
   import hrlv_pkg::*;
(
   input  logic       req_valid,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_marker,
   output logic       req_stall,
   input  logic       q_full,
   output logic       push,
   output token_type  push_tok
);

   logic [7:0] b;

   assign b = req_data_byte;

   // Accept whenever the queue has room
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // Character classes
   always_comb begin
      push_tok            = '0;
      push_tok.end_marker = req_end_marker;
      push_tok.is_sp      = (b == CH_SP);
      push_tok.is_cr      = (b == CH_CR);
      push_tok.is_lf      = (b == CH_LF);
      push_tok.is_slash   = (b == CH_SLASH);
      push_tok.path_ok    = (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
                            || (b == CH_DOT) || (b == CH_SLASH);
      push_tok.vers_ok    = (b > CH_SP) && (b < CH_DEL);
      push_tok.is_g       = (b == 8'h47);
      push_tok.is_e       = (b == 8'h45);
      push_tok.is_t       = (b == 8'h54);
      push_tok.is_p       = (b == 8'h50);
      push_tok.is_o       = (b == 8'h4F);
      push_tok.is_s       = (b == 8'h53);
   end

endmodule

FILE: hw/rtl/hrlv_queue.sv
// ----------------------------------------------------------------------------
// HTTP request line validator: token queue
// Short FIFO that decouples the classifier from the parser.
// ----------------------------------------------------------------------------
`include "http_request_line_validator_unit_macros.svh"

module hrlv_queue
   import hrlv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  token_type     push_tok,
   output logic          full,
   input  logic          pop,
   output queue_out_type head
);

   token_type            mem_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff;
   logic                 push_ok;
   logic                 pop_ok;

   assign full      = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign push_ok   = push && !full;
   assign pop_ok    = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.tok   = mem_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + Q_CNT_W'(1);
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - Q_CNT_W'(1);
         end
      end
   end

   `HRLV_ASSERT_NOW(a_q_bound, 1'b1, count_ff <= Q_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `HRLV_ASSERT_NOW(a_q_ptrs, 1'b1,
      (wr_ptr_ff - rd_ptr_ff) == count_ff[Q_PTR_W-1:0], "pointer skew")
   `HRLV_ASSERT_NEXT(a_q_up, push_ok && !pop_ok,
      count_ff == $past(count_ff) + Q_CNT_W'(1), "count up")

endmodule

FILE: hw/rtl/hrlv_back.sv
// ----------------------------------------------------------------------------
// HTTP request line validator: back end
// Runs the request parser on classified bytes and holds the verdict register.
// ----------------------------------------------------------------------------
`include "http_request_line_validator_unit_macros.svh"

module hrlv_back
   import hrlv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [2:0]    rsp_status,
   output logic          rsp_verb_code,
   output logic [15:0]   rsp_path_length,
   output logic [15:0]   rsp_version_length,
   output logic [3:0]    rsp_header_count
);

   back_state_type st_ff;
   back_state_type st_in;
   back_state_type snap;
   logic           emit;
   status_type     code;

   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic           rsp_verb_ff;
   logic [15:0]    rsp_path_ff;
   logic [15:0]    rsp_vers_ff;
   logic [3:0]     rsp_hdr_ff;
   logic           verb_in;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // One verb byte against GET and POST
   function automatic back_state_type verb_byte(input back_state_type s, input token_type t);
      back_state_type r;
      logic           get_hit;
      logic           post_hit;
      r        = s;
      get_hit  = (s.vpos == 3'd0 && t.is_g) || (s.vpos == 3'd1 && t.is_e) ||
                 (s.vpos == 3'd2 && t.is_t);
      post_hit = (s.vpos == 3'd0 && t.is_p) || (s.vpos == 3'd1 && t.is_o) ||
                 (s.vpos == 3'd2 && t.is_s) || (s.vpos == 3'd3 && t.is_t);
      if (!get_hit) r.vcand[0] = 1'b0;
      if (!post_hit) r.vcand[1] = 1'b0;
      if (s.vpos != 3'd7) r.vpos = s.vpos + 3'd1;
      if (r.vcand == 2'b00) r.phase = PH_BADVERB;
      return r;
   endfunction

   function automatic back_state_type verb_end(input back_state_type s);
      back_state_type r;
      r = s;
      if (s.vcand[0] && s.vpos == 3'd3) begin
         r.vcand = VC_GET;
         r.phase = PH_GAP;
      end else if (s.vcand[1] && s.vpos == 3'd4) begin
         r.vcand = VC_POST;
         r.phase = PH_GAP;
      end else begin
         r.phase = PH_BADVERB;
      end
      return r;
   endfunction

   // One request-line byte other than LF
   function automatic back_state_type line_byte(input back_state_type s, input token_type t);
      back_state_type r;
      r = s;
      case (s.phase)
         PH_SKIP: begin
            if (!t.is_sp) begin
               r.phase = PH_VERB;
               r       = verb_byte(r, t);
            end
         end
         PH_VERB: begin
            if (t.is_sp) r = verb_end(s);
            else r = verb_byte(s, t);
         end
         PH_GAP: begin
            if (!t.is_sp) begin
               if (t.is_slash) begin
                  r.phase    = PH_PATH;
                  r.path_cnt = sat_inc(s.path_cnt);
               end else begin
                  r.phase = PH_BADPATH;
               end
            end
         end
         PH_PATH: begin
            if (t.is_sp) r.phase = PH_VERS;
            else if (!t.path_ok) r.phase = PH_BADPATH;
            else r.path_cnt = sat_inc(s.path_cnt);
         end
         PH_VERS: begin
            if (!t.vers_ok) r.phase = PH_BADVERS;
            else r.vers_cnt = sat_inc(s.vers_cnt);
         end
         default: ;
      endcase
      return r;
   endfunction

   // LF that closes the request line
   function automatic void line_end(input back_state_type s, output back_state_type r,
                                    output logic e, output status_type c);
      r = s;
      e = 1'b1;
      c = ST_BAD_VERSION;
      case (s.phase)
         PH_SKIP:    c = ST_BAD_VERB;
         PH_VERB: begin
            r = verb_end(s);
            c = (r.phase == PH_BADVERB) ? ST_BAD_VERB : ST_BAD_PATH;
         end
         PH_GAP:     c = ST_BAD_PATH;
         PH_PATH:    c = ST_BAD_VERSION;
         PH_VERS: begin
            if (s.vers_cnt != 16'd0) begin
               e          = 1'b0;
               r.phase    = PH_HEAD;
               r.line_pos = LP_START;
               r.bare     = 1'b0;
            end
         end
         PH_BADVERB: c = ST_BAD_VERB;
         PH_BADPATH: c = ST_BAD_PATH;
         default:    c = ST_BAD_VERSION;
      endcase
   endfunction

   // Take a token when the verdict register is free or draining
   assign pop = head.valid && (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      back_state_type s;
      back_state_type s2;
      logic           e2;
      status_type     c2;
      logic           line_closed;
      s           = st_ff;
      s2          = st_ff;
      e2          = 1'b0;
      c2          = ST_OK;
      line_closed = 1'b0;
      emit        = 1'b0;
      code        = ST_OK;
      snap        = st_ff;
      if (pop) begin
         if (head.tok.end_marker) begin
            if (s.phase != PH_DONE) begin
               emit = 1'b1;
               code = ((s.phase == PH_HEAD || s.phase == PH_TAIL) &&
                       s.line_pos == LP_START && s.bare) ? ST_OK : ST_IO;
            end
            snap = s;
            s    = BACK_RESET;
         end else if (s.phase == PH_DONE) begin
            s = st_ff;
         end else if (s.phase == PH_HEAD || s.phase == PH_TAIL) begin
            if (head.tok.is_lf) begin
               if (s.phase == PH_HEAD) begin
                  if (s.line_pos == LP_CR) s.phase = PH_TAIL;
                  else if (s.hdr_cnt < HEADER_LIMIT) s.hdr_cnt = s.hdr_cnt + 4'd1;
               end
               s.bare     = (s.line_pos == LP_CR);
               s.line_pos = LP_START;
            end else if (s.line_pos == LP_START && head.tok.is_cr) begin
               s.line_pos = LP_CR;
            end else begin
               s.line_pos = LP_TEXT;
            end
         end else begin
            if (s.pend_cr) begin
               s.pend_cr = 1'b0;
               if (head.tok.is_lf) begin
                  line_end(s, s2, e2, c2);
                  s           = s2;
                  line_closed = 1'b1;
               end else begin
                  s = line_byte(s, CR_TOKEN);
               end
            end
            if (!line_closed) begin
               if (head.tok.is_lf) begin
                  line_end(s, s2, e2, c2);
                  s = s2;
               end else if (head.tok.is_cr) begin
                  s.pend_cr = 1'b1;
               end else begin
                  s = line_byte(s, head.tok);
               end
            end
            if (e2) begin
               emit    = 1'b1;
               code    = c2;
               snap    = s;
               s.phase = PH_DONE;
            end
         end
      end
      st_in = s;
   end

   // Verdict fields
   always_comb begin
      case (snap.phase)
         PH_GAP, PH_PATH, PH_VERS, PH_BADPATH, PH_BADVERS, PH_HEAD, PH_TAIL:
            verb_in = (snap.vcand == VC_POST);
         default:
            verb_in = 1'b0;
      endcase
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BACK_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

   // Verdict register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_status_ff <= code;
         rsp_verb_ff   <= verb_in;
         rsp_path_ff   <= snap.path_cnt;
         rsp_vers_ff   <= snap.vers_cnt;
         rsp_hdr_ff    <= snap.hdr_cnt;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_verb_code      = rsp_verb_ff;
   assign rsp_path_length    = rsp_path_ff;
   assign rsp_version_length = rsp_vers_ff;
   assign rsp_header_count   = rsp_hdr_ff;

   `HRLV_ASSERT_NEXT(a_end_clears, pop && head.tok.end_marker,
      st_ff == BACK_RESET, "no reset at end")
   `HRLV_ASSERT_NOW(a_verb_known,
      st_ff.phase == PH_GAP || st_ff.phase == PH_PATH || st_ff.phase == PH_VERS,
      $onehot(st_ff.vcand), "verb not resolved")
   `HRLV_ASSERT_NOW(a_hdr_bound, 1'b1, st_ff.hdr_cnt <= HEADER_LIMIT, "header count overrun")
   `HRLV_ASSERT_NEXT(a_verdict_load, pop && emit, rsp_valid_ff, "verdict dropped")

endmodule

FILE: hw/rtl/http_request_line_validator_unit.sv
// ----------------------------------------------------------------------------
// HTTP request line validator: top level
// Checks a byte stream holding one request and returns one verdict per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one byte per request (req_data_byte), or the end of the
//   stream (req_end_marker = 1). rsp_ channel returns the verdict: status, verb,
//   path and version lengths, and the header line count.
//   A request is taken on a rising edge with valid high and stall low.
//   Throughput: one byte per cycle while no held verdict is stalled; the
//   parser handles one queued byte each cycle and its single state update
//   sets that figure. A verdict shows on rsp_valid once the byte or end
//   marker that decided it has been taken: queue write on the accepting
//   edge, then parser and verdict register when the parser pops it.
//   A 4-entry byte queue sits between the classifier and the parser; while the
//   receiver stalls a held verdict, the parser stops taking bytes, the queue
//   fills, and req_stall rises once the queue is full.
//   Synchronous reset clears the queue, the parser and the verdict register;
//   every end marker also returns the parser to its reset state.
// ----------------------------------------------------------------------------
module http_request_line_validator_unit
   import hrlv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_marker,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_verb_code,
   output logic [15:0] rsp_path_length,
   output logic [15:0] rsp_version_length,
   output logic [3:0]  rsp_header_count
);

   logic          q_full;
   logic          push;
   token_type     push_tok;
   logic          pop;
   queue_out_type head;

   // Byte classifier
   hrlv_front u_front (
      .req_valid      (req_valid),
      .req_data_byte  (req_data_byte),
      .req_end_marker (req_end_marker),
      .req_stall      (req_stall),
      .q_full         (q_full),
      .push           (push),
      .push_tok       (push_tok)
   );

   // Token queue
   hrlv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .full     (q_full),
      .pop      (pop),
      .head     (head)
   );

   // Parser and verdict register
   hrlv_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_verb_code      (rsp_verb_code),
      .rsp_path_length    (rsp_path_length),
      .rsp_version_length (rsp_version_length),
      .rsp_header_count   (rsp_header_count)
   );

endmodule

FILE: tb/http_request_line_validator_unit_tb.sv
// ----------------------------------------------------------------------------
// HTTP request line validator: testbench
// Streams requests one byte per handshake, with directed corner cases
// first and then random well-formed, broken and noisy requests. It
// predicts each verdict from its own model of the parser and compares
// every returned verdict, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_line_validator_unit_tb
   import hrlv_pkg::*;
();

   localparam int          IDLE_LIMIT   = 2000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          RANDOM_BYTES = 950;
   localparam logic [23:0] GET_WORD     = "GET";
   localparam logic [31:0] POST_WORD    = "POST";

   // Expected verdict fields
   typedef struct packed {
      status_type  status;
      logic        verb;
      logic [15:0] path_len;
      logic [15:0] vers_len;
      logic [3:0]  hdrs;
   } verdict_type;

   // Parser model plus the queue of verdicts it expects
   class verdict_tracker;
      phase_type   ph;
      logic [2:0]  vpos;
      logic [1:0]  vcand;
      logic [15:0] path_n;
      logic [15:0] vers_n;
      logic [3:0]  hdr_n;
      logic [1:0]  lpos;
      bit          bare;
      bit          pend_cr;
      bit          sent;
      verdict_type pending_verdicts[$];
      int          failures;

      function new();
         clear();
         failures = 0;
      endfunction

      function void clear();
         ph      = PH_SKIP;
         vpos    = 3'd0;
         vcand   = VC_BOTH;
         path_n  = 16'd0;
         vers_n  = 16'd0;
         hdr_n   = 4'd0;
         lpos    = LP_START;
         bare    = 1'b0;
         pend_cr = 1'b0;
         sent    = 1'b0;
      endfunction

      function bit verb_taken();
         return ph inside {PH_GAP, PH_PATH, PH_VERS, PH_BADPATH, PH_BADVERS,
                           PH_HEAD, PH_TAIL};
      endfunction

      function void post(status_type s);
         verdict_type v;
         v.status   = s;
         v.verb     = verb_taken() && (vcand == VC_POST);
         v.path_len = path_n;
         v.vers_len = vers_n;
         v.hdrs     = hdr_n;
         pending_verdicts.push_back(v);
         sent = 1'b1;
         ph   = PH_DONE;
      endfunction

      function logic [15:0] sat_inc(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      // Narrow the GET/POST candidates by one letter
      function void verb_char(logic [7:0] b);
         int p;
         p = vpos;
         if (p >= 3) vcand &= VC_POST;
         else if (b != GET_WORD[8 * (2 - p) +: 8]) vcand &= VC_POST;
         if (p >= 4) vcand &= VC_GET;
         else if (b != POST_WORD[8 * (3 - p) +: 8]) vcand &= VC_GET;
         if (p < 7) vpos = vpos + 3'd1;
         if (vcand == 2'b00) ph = PH_BADVERB;
      endfunction

      function void verb_close();
         if (vcand[0] && vpos == 3'd3) begin
            vcand = VC_GET;
            ph    = PH_GAP;
         end else if (vcand[1] && vpos == 3'd4) begin
            vcand = VC_POST;
            ph    = PH_GAP;
         end else begin
            ph = PH_BADVERB;
         end
      endfunction

      function bit path_char(logic [7:0] b);
         return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
                (b >= "a" && b <= "z") || b == CH_DOT || b == CH_SLASH;
      endfunction

      // Request line byte other than LF; a CR here is literal
      function void line_char(logic [7:0] b);
         case (ph)
            PH_SKIP: begin
               if (b != CH_SP) begin
                  ph = PH_VERB;
                  verb_char(b);
               end
            end
            PH_VERB: begin
               if (b == CH_SP) verb_close();
               else verb_char(b);
            end
            PH_GAP: begin
               if (b != CH_SP) begin
                  if (b != CH_SLASH) ph = PH_BADPATH;
                  else begin
                     ph     = PH_PATH;
                     path_n = sat_inc(path_n);
                  end
               end
            end
            PH_PATH: begin
               if (b == CH_SP) ph = PH_VERS;
               else if (!path_char(b)) ph = PH_BADPATH;
               else path_n = sat_inc(path_n);
            end
            PH_VERS: begin
               if (b <= CH_SP || b >= CH_DEL) ph = PH_BADVERS;
               else vers_n = sat_inc(vers_n);
            end
            default: ;
         endcase
      endfunction

      // LF that ends the request line
      function void line_close();
         case (ph)
            PH_SKIP:    post(ST_BAD_VERB);
            PH_VERB: begin
               verb_close();
               post(ph == PH_BADVERB ? ST_BAD_VERB : ST_BAD_PATH);
            end
            PH_GAP:     post(ST_BAD_PATH);
            PH_PATH:    post(ST_BAD_VERSION);
            PH_VERS: begin
               if (vers_n == 16'd0) post(ST_BAD_VERSION);
               else begin
                  ph   = PH_HEAD;
                  lpos = LP_START;
                  bare = 1'b0;
               end
            end
            PH_BADVERB: post(ST_BAD_VERB);
            PH_BADPATH: post(ST_BAD_PATH);
            default:    post(ST_BAD_VERSION);
         endcase
      endfunction

      // Accepted request: one byte or the end of the stream
      function void take_byte(logic [7:0] b, logic end_marker);
         bit good;
         bit was_bare;
         if (end_marker) begin
            if (!sent && ph != PH_DONE) begin
               good = (ph == PH_HEAD || ph == PH_TAIL) && lpos == LP_START && bare;
               post(good ? ST_OK : ST_IO);
            end
            clear();
            return;
         end
         if (ph == PH_DONE) return;
         // Header section: only line shapes matter
         if (ph == PH_HEAD || ph == PH_TAIL) begin
            if (b == CH_LF) begin
               was_bare = (lpos == LP_CR);
               if (ph == PH_HEAD) begin
                  if (was_bare) ph = PH_TAIL;
                  else if (hdr_n < HEADER_LIMIT) hdr_n = hdr_n + 4'd1;
               end
               bare = was_bare;
               lpos = LP_START;
            end else if (lpos == LP_START && b == CH_CR) begin
               lpos = LP_CR;
            end else begin
               lpos = LP_TEXT;
            end
            return;
         end
         // Request line: a CR is held back until the next byte shows its role
         if (pend_cr) begin
            pend_cr = 1'b0;
            if (b == CH_LF) begin
               line_close();
               return;
            end
            line_char(CH_CR);
         end
         if (b == CH_LF) line_close();
         else if (b == CH_CR) pend_cr = 1'b1;
         else line_char(b);
      endfunction

      function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
         if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            failures++;
         end
      endfunction

      function void match_verdict(logic [2:0] status, logic verb, logic [15:0] plen,
                                  logic [15:0] vlen, logic [3:0] hcnt);
         verdict_type v;
         if (pending_verdicts.size() == 0) begin
            $error("verdict with none expected: status %0d", status);
            failures++;
            return;
         end
         v = pending_verdicts.pop_front();
         compare_field("status", 16'(v.status), 16'(status));
         compare_field("verb_code", 16'(v.verb), 16'(verb));
         compare_field("path_length", v.path_len, plen);
         compare_field("version_length", v.vers_len, vlen);
         compare_field("header_count", 16'(v.hdrs), 16'(hcnt));
      endfunction
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte  = 8'd0;
   logic        req_end_marker = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_verb_code;
   logic [15:0] rsp_path_length;
   logic [15:0] rsp_version_length;
   logic [3:0]  rsp_header_count;

   verdict_tracker sb = new();
   logic [7:0]     stream_q[$];
   string          path_chars =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789./";
   bit             quiet       = 1'b0;
   bit             hold_req    = 1'b0;
   int             idle_cycles = 0;
   int             random_bytes = 0;

   http_request_line_validator_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_marker     (req_end_marker),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_verb_code      (rsp_verb_code),
      .rsp_path_length    (rsp_path_length),
      .rsp_version_length (rsp_version_length),
      .rsp_header_count   (rsp_header_count)
   );

   always #2 clock = ~clock;

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
   endfunction

   function automatic void add_eol();
      if ($urandom_range(0, 9) != 0) stream_q.push_back(CH_CR);
      stream_q.push_back(CH_LF);
   endfunction

   // Random request: mostly well formed, some broken, some pure noise
   function automatic void build_request();
      int    n;
      int    k;
      int    pos;
      string verb_letters = "GETPOS";
      stream_q.delete();
      if ($urandom_range(0, 19) == 0) begin
         n = $urandom_range(0, 40);
         repeat (n) begin
            case ($urandom_range(0, 5))
               0:       stream_q.push_back(CH_LF);
               1:       stream_q.push_back(CH_CR);
               2:       stream_q.push_back(CH_SP);
               default: stream_q.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         return;
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) stream_q.push_back(CH_SP);
      k = $urandom_range(0, 9);
      if (k < 5) add_text("GET");
      else if (k < 9) add_text("POST");
      else repeat ($urandom_range(1, 5)) stream_q.push_back(verb_letters[$urandom_range(0, 5)]);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
      repeat (n) stream_q.push_back(CH_SP);
      stream_q.push_back(CH_SLASH);
      repeat ($urandom_range(0, 12))
         stream_q.push_back(path_chars[$urandom_range(0, path_chars.len() - 1)]);
      stream_q.push_back(CH_SP);
      if ($urandom_range(0, 1) == 0) add_text("HTTP/1.1");
      else repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      add_eol();
      // Header lines, sometimes past the saturation limit
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 3);
      repeat (n) begin
         repeat ($urandom_range(1, 12))
            stream_q.push_back(($urandom_range(0, 19) == 0) ? CH_CR :
                               8'($urandom_range(8'h20, 8'h7E)));
         add_eol();
      end
      case ($urandom_range(0, 19))
         0: ;
         1: stream_q.push_back(CH_LF);
         2: begin
            stream_q.push_back(CH_CR);
            stream_q.push_back(CH_CR);
            stream_q.push_back(CH_LF);
         end
         default: begin
            stream_q.push_back(CH_CR);
            stream_q.push_back(CH_LF);
         end
      endcase
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom_range(0, 255)));
      // Occasional damage: replace, insert, drop, or cut short
      if ($urandom_range(0, 4) == 0 && stream_q.size() > 0) begin
         pos = $urandom_range(0, stream_q.size() - 1);
         case ($urandom_range(0, 3))
            0: stream_q[pos] = 8'($urandom_range(0, 255));
            1: stream_q.insert(pos, 8'($urandom_range(0, 255)));
            2: stream_q.delete(pos);
            default: while (stream_q.size() > pos) void'(stream_q.pop_back());
         endcase
      end
   endfunction

   // One request on the input channel; entered and left just after a falling edge
   task automatic send_item(logic [7:0] d, logic e);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_data_byte  = d;
      req_end_marker = e;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_request();
      foreach (stream_q[i]) send_item(stream_q[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Receiver: random stall bursts, plus one long hold when asked
   initial begin
      int hold_left;
      int burst_left;
      hold_left  = 0;
      burst_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (burst_left > 0) begin
            rsp_stall = 1'b1;
            burst_left--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall  = 1'b1;
            burst_left = $urandom_range(1, 12) - 1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Both channels sampled at the rising edge; inputs noted before verdicts
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.take_byte(req_data_byte, req_end_marker);
         if (rsp_valid && !rsp_stall)
            sb.match_verdict(rsp_status, rsp_verb_code, rsp_path_length,
                             rsp_version_length, rsp_header_count);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("http_request_line_validator_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      string cases[$];
      bit    held;
      bit    paused;
      cases = {
         "GET / HTTP/1.1\015\012\015\012",
         "  POST /a.Z/09 v\015\012H: 1\015\012\015\012",
         "",
         "\015\012",
         "   \012",
         "GETX / v\012",
         "get / v\012",
         "POS / v\012",
         "GET\015\012",
         "POST   \012",
         "GET /\012",
         "GET / \015\012",
         "GET /  v\012",
         "GET /a\015b v\012",
         "GET x v\012",
         "GET / \200\012",
         "GET / a\177\012",
         "GET / v",
         "GET / v\015\012A\015\012",
         "GET / v\015\012\015\012extra",
         "GET / v\012\015\012\015\012",
         "GETX\012trailing junk",
         "GET / v\015\012\015\015\012"
      };
      held   = 1'b0;
      paused = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed corner cases
      foreach (cases[i]) begin
         stream_q.delete();
         add_text(cases[i]);
         send_request();
      end
      // Header count saturation
      stream_q.delete();
      add_text("POST /h v\015\012");
      repeat (12) add_text("K: v\015\012");
      add_text("\015\012");
      send_request();

      // Random requests; the last stretch runs without idling
      while (random_bytes < RANDOM_BYTES) begin
         if (random_bytes > RANDOM_BYTES - 200) quiet = 1'b1;
         if (!held && random_bytes >= 300) begin
            hold_req = 1'b1;
            held     = 1'b1;
         end
         if (!paused && random_bytes >= 700) begin
            req_valid = 1'b0;
            while (sb.pending_verdicts.size() != 0) @(negedge clock);
            paused = 1'b1;
         end
         build_request();
         random_bytes += stream_q.size() + 1;
         send_request();
      end
      req_valid = 1'b0;

      // Drain, then give the pipeline time to show any stray verdict
      while (sb.pending_verdicts.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.failures == 0 && sb.pending_verdicts.size() == 0)
         $display("http_request_line_validator_unit: match");
      else
         $display("http_request_line_validator_unit: mismatch");
      $finish;
   end

endmodule

FILE: http_request_line_validator_unit.f
+incdir+hw/rtl
hw/rtl/hrlv_pkg.sv
hw/rtl/hrlv_front.sv
hw/rtl/hrlv_queue.sv
hw/rtl/hrlv_back.sv
hw/rtl/http_request_line_validator_unit.sv
tb/http_request_line_validator_unit_tb.sv
